// ===== design/vrms_pkg.sv =====
// vrms_pkg: shared types, widths and command encodings of the vibration rms monitor
// used by the controller, the datapath, the square root unit and the top level
`default_nettype none

package vrms_pkg;

  // field and arithmetic widths
  localparam int unsigned ACCEL_W = 16;
  localparam int unsigned MAG_W = 16;
  localparam int unsigned PROD_W = 2 * MAG_W;
  localparam int unsigned RAD_W = PROD_W;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W = ROOT_W + 2;

  // default window length, a power of two
  localparam int unsigned SAMPLES_DEFAULT = 16;

  // input request: one three-axis sample, signed Q4.12 g
  typedef struct packed {
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
  } vrms_in_t;

  // output request: magnitude and window rms, unsigned Q4.12 g
  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [MAG_W-1:0] rms_level;
  } vrms_out_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_ACC_Z,
    ST_ROOT_MAG,
    ST_WAIT_MAG,
    ST_MUL_OLD,
    ST_MUL_NEW,
    ST_ADD_NEW,
    ST_ROOT_RMS,
    ST_WAIT_RMS,
    ST_OUTPUT
  } vrms_state_t;

  // multiplier operand select
  typedef enum logic [2:0] {
    MUL_X,
    MUL_Y,
    MUL_Z,
    MUL_OLD,
    MUL_MAG
  } vrms_mul_sel_t;

  // square root radicand select
  typedef enum logic {
    SRC_ACC,
    SRC_TOTAL
  } vrms_sqrt_src_t;

  // commands from controller to datapath
  typedef struct packed {
    logic           latch_in;
    vrms_mul_sel_t  mul_sel;
    logic           acc_load;
    logic           acc_add;
    logic           sqrt_start;
    vrms_sqrt_src_t sqrt_src;
    logic           mag_load;
    logic           total_sub;
    logic           total_add;
    logic           ring_write;
    logic           rms_load;
    logic           out_load;
  } vrms_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sqrt_busy;
    logic sqrt_done;
  } vrms_status_t;

endpackage

`default_nettype wire

// ===== design/vibration_rms_monitor.sv =====
// vibration_rms_monitor: moving-window rms of accelerometer vector magnitude
// input channel takes one three-axis sample request (in_valid/in_ready/in_data),
// output channel gives magnitude and window rms (out_valid/out_ready/out_data).
// one sample is worked on at a time; in_ready is high only while the block waits
// for a new sample. after the accepting edge, the shared squarer works on the axes
// (ST_MUL_X to ST_ACC_Z), a 16-step pass of the iterative square root unit gives
// the magnitude, the ring and running total are updated (ST_MUL_OLD, ST_MUL_NEW,
// ST_ADD_NEW), a second 16-step pass gives the rms, and the output register is
// loaded, which raises out_valid. the next sample is accepted in the idle cycle
// right after the output register is loaded.
// the output register holds a finished result while the receiver stalls; the
// next sample is still accepted and worked on, and waits in its last step until
// the output register is free.
// reset empties the window (all stored magnitudes read as zero through per-entry
// valid bits), clears the running total and the write slot, and drops any
// pending result. the window length SAMPLES must be a power of two.
`default_nettype none

module vibration_rms_monitor #(
  parameter int unsigned SAMPLES = vrms_pkg::SAMPLES_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire vrms_pkg::vrms_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output vrms_pkg::vrms_out_t     out_data
);
  import vrms_pkg::*;

  vrms_cmd_t    cmd;
  vrms_status_t status;

  // sequencer
  vrms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and storage
  vrms_datapath #(
    .SAMPLES (SAMPLES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  // square root is never restarted while a pass is running
  assert property (@(posedge clk) disable iff (rst)
    cmd.sqrt_start |-> !status.sqrt_busy)
    else $error("square root started while busy");

  // a finished pass follows a busy period
  assert property (@(posedge clk) disable iff (rst)
    status.sqrt_done |-> $past(status.sqrt_busy))
    else $error("square root done without a running pass");

  // loading the output register always raises out_valid
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("output loaded but not presented");

  // a new sample is never taken while the ring or total is being updated
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !(cmd.total_sub || cmd.total_add || cmd.ring_write))
    else $error("sample accepted during window update");

endmodule

`default_nettype wire

// ===== design/vrms_sqrt.sv =====
// vrms_sqrt: iterative floor square root, one result bit per cycle
// depends on vrms_pkg for widths
`default_nettype none

module vrms_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [vrms_pkg::RAD_W-1:0]   radicand,
  output logic                              busy,
  output logic                              done,
  output logic [vrms_pkg::ROOT_W-1:0]       root
);
  import vrms_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem_shift;
  logic [REM_W-1:0] trial;
  logic             fits;

  // one restoring step on the next two radicand bits
  always_comb begin
    rem_shift = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial     = {root, 2'b01};
    fits      = (rem_shift >= trial);
  end

  // control: busy flag, step counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      if (fits) begin
        rem  <= rem_shift - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_shift;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/vrms_ctrl.sv =====
// vrms_ctrl: sequencing state machine and output handshake of the rms monitor
// depends on vrms_pkg for states, commands and status
`default_nettype none

module vrms_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  input  wire vrms_pkg::vrms_status_t status,
  output vrms_pkg::vrms_cmd_t         cmd
);
  import vrms_pkg::*;

  vrms_state_t state;
  vrms_state_t state_next;
  logic        out_valid_next;

  // state and output flag registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel  = MUL_X;
    cmd.sqrt_src = SRC_ACC;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        cmd.mul_sel = MUL_X;
        state_next  = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd.mul_sel  = MUL_Y;
        cmd.acc_load = 1'b1;
        state_next   = ST_MUL_Z;
      end
      ST_MUL_Z: begin
        cmd.mul_sel = MUL_Z;
        cmd.acc_add = 1'b1;
        state_next  = ST_ACC_Z;
      end
      ST_ACC_Z: begin
        cmd.acc_add = 1'b1;
        state_next  = ST_ROOT_MAG;
      end
      ST_ROOT_MAG: begin
        cmd.sqrt_start = 1'b1;
        cmd.sqrt_src   = SRC_ACC;
        state_next     = ST_WAIT_MAG;
      end
      ST_WAIT_MAG: begin
        if (status.sqrt_done) begin
          cmd.mag_load = 1'b1;
          state_next   = ST_MUL_OLD;
        end
      end
      ST_MUL_OLD: begin
        cmd.mul_sel = MUL_OLD;
        state_next  = ST_MUL_NEW;
      end
      ST_MUL_NEW: begin
        cmd.mul_sel   = MUL_MAG;
        cmd.total_sub = 1'b1;
        state_next    = ST_ADD_NEW;
      end
      ST_ADD_NEW: begin
        cmd.total_add  = 1'b1;
        cmd.ring_write = 1'b1;
        state_next     = ST_ROOT_RMS;
      end
      ST_ROOT_RMS: begin
        cmd.sqrt_start = 1'b1;
        cmd.sqrt_src   = SRC_TOTAL;
        state_next     = ST_WAIT_RMS;
      end
      ST_WAIT_RMS: begin
        if (status.sqrt_done) begin
          cmd.rms_load = 1'b1;
          state_next   = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output valid: set on load, cleared when the request is taken
  always_comb begin
    out_valid_next = cmd.out_load | (out_valid & ~out_ready);
  end

endmodule

`default_nettype wire

// ===== design/vrms_datapath.sv =====
// vrms_datapath: squares, magnitude ring, running square total and output register
// depends on vrms_pkg and instantiates vrms_sqrt
`default_nettype none

module vrms_datapath #(
  parameter int unsigned SAMPLES = vrms_pkg::SAMPLES_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire vrms_pkg::vrms_in_t   in_data,
  input  wire vrms_pkg::vrms_cmd_t  cmd,
  output vrms_pkg::vrms_status_t    status,
  output vrms_pkg::vrms_out_t       out_data
);
  import vrms_pkg::*;

  localparam int unsigned SLOT_W = $clog2(SAMPLES);
  localparam int unsigned TOTAL_W = PROD_W + SLOT_W;

  // absolute value of a signed sample, -32768 maps to 32768
  function automatic logic [MAG_W-1:0] abs_val(input logic signed [ACCEL_W-1:0] v);
    logic signed [ACCEL_W-1:0] neg;
    neg = -v;
    return v[ACCEL_W-1] ? MAG_W'(neg) : MAG_W'(v);
  endfunction

  logic [MAG_W-1:0]   abs_x;
  logic [MAG_W-1:0]   abs_y;
  logic [MAG_W-1:0]   abs_z;
  logic [MAG_W-1:0]   mul_a;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  acc;
  logic [MAG_W-1:0]   mag;
  logic [MAG_W-1:0]   rms;
  logic [TOTAL_W-1:0] total;
  logic [SLOT_W-1:0]  slot;
  logic [MAG_W-1:0]   ring [SAMPLES];
  logic [SAMPLES-1:0] ring_valid;
  logic [MAG_W-1:0]   old_q;
  logic               old_valid_q;
  logic [MAG_W-1:0]   old_mag;
  logic [RAD_W-1:0]   radicand;
  logic [ROOT_W-1:0]  root;

  // latch absolute values of the accepted sample
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      abs_x <= abs_val(in_data.accel_x);
      abs_y <= abs_val(in_data.accel_y);
      abs_z <= abs_val(in_data.accel_z);
    end
  end

  // unused entries read as zero
  assign old_mag = old_valid_q ? old_q : '0;

  // shared squarer, product registered
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_X:   mul_a = abs_x;
      MUL_Y:   mul_a = abs_y;
      MUL_Z:   mul_a = abs_z;
      MUL_OLD: mul_a = old_mag;
      MUL_MAG: mul_a = mag;
      default: mul_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_a);
  end

  // sum of squared axes
  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      acc <= prod;
    end else if (cmd.acc_add) begin
      acc <= acc + prod;
    end
  end

  // running total of squared ring entries and write slot
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      slot  <= '0;
    end else begin
      if (cmd.total_sub) begin
        total <= total - TOTAL_W'(prod);
      end else if (cmd.total_add) begin
        total <= total + TOTAL_W'(prod);
      end
      if (cmd.ring_write) begin
        slot <= slot + SLOT_W'(1);
      end
    end
  end

  // magnitude ring with registered read of the current slot
  always_ff @(posedge clk) begin
    if (cmd.ring_write) begin
      ring[slot] <= mag;
    end
    old_q <= ring[slot];
  end

  // per-entry valid bits stand in for the reset clear of the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid  <= '0;
      old_valid_q <= 1'b0;
    end else begin
      if (cmd.ring_write) begin
        ring_valid[slot] <= 1'b1;
      end
      old_valid_q <= ring_valid[slot];
    end
  end

  // square root unit, shared by magnitude and rms
  assign radicand = (cmd.sqrt_src == SRC_TOTAL) ? total[TOTAL_W-1 -: RAD_W] : acc;

  vrms_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (radicand),
    .busy     (status.sqrt_busy),
    .done     (status.sqrt_done),
    .root     (root)
  );

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.mag_load) begin
      mag <= root;
    end
    if (cmd.rms_load) begin
      rms <= root;
    end
    if (cmd.out_load) begin
      out_data.magnitude <= mag;
      out_data.rms_level <= rms;
    end
  end

endmodule

`default_nettype wire
